/* hw/rtl/one_wire_rom_search_unit_defines.svh */
// assertion macros shared by the search unit rtl
// expects signals named clk and rst_n in the including module
`ifndef ONE_WIRE_ROM_SEARCH_UNIT_DEFINES_SVH
`define ONE_WIRE_ROM_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define OWS_ASSERT_NOW(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// next-cycle implication
`define OWS_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hw/rtl/ows_pkg.sv */
// types, codes and constants of the one-wire rom search unit
// no dependencies
package ows_pkg;

    typedef enum logic [2:0] {
        OP_FIRST    = 3'd0,
        OP_NEXT     = 3'd1,
        OP_VERIFY   = 3'd2,
        OP_TARGET   = 3'd3,
        OP_SKIP     = 3'd4,
        OP_PRESENCE = 3'd5,
        OP_BITS     = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ACT_BUS_RESET = 2'd0,
        ACT_SEND_CMD  = 2'd1,
        ACT_WRITE_DIR = 2'd2,
        ACT_FINISH    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_PRESENCE = 3'b010,
        PH_BITS     = 3'b100
    } phase_t;

    localparam logic [7:0] SEARCH_CMD   = 8'hF0;
    localparam logic [6:0] END_POSITION = 7'd65;
    localparam logic [6:0] FAMILY_LIMIT = 7'd9;
    localparam logic [6:0] ROM_BITS     = 7'd64;
    localparam logic [7:0] CRC_POLY     = 8'h8C;

    typedef struct packed {
        action_t     action;
        logic [7:0]  command_byte;
        logic        direction;
        logic        found;
        logic [63:0] rom_code;
        logic        is_last_device;
        logic        last_of_run;
    } res_t;

    // up to two results caused by one request
    typedef struct packed {
        logic [1:0] cnt;
        res_t       first;
        res_t       second;
    } push_t;

    // dallas crc-8, reflected, one byte
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] value);
        logic [7:0] c;
        c = crc ^ value;
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/ows_if.sv */
// request and result channels of the one-wire rom search unit
// valid/ready handshake, no dependencies
interface ows_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] family_byte;
    logic       presence;
    logic       id_bit;
    logic       comp_bit;

    modport source (output valid, op, family_byte, presence, id_bit, comp_bit,
                    input ready);
    modport sink (input valid, op, family_byte, presence, id_bit, comp_bit,
                  output ready);
endinterface

interface ows_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  command_byte;
    logic        direction;
    logic        found;
    logic [63:0] rom_code;
    logic        is_last_device;
    logic        last_of_run;

    modport source (output valid, action, command_byte, direction, found, rom_code,
                    is_last_device, last_of_run, input ready);
    modport sink (input valid, action, command_byte, direction, found, rom_code,
                  is_last_device, last_of_run, output ready);
endinterface

/* hw/rtl/ows_core.sv */
// search state registers and per-request next-state logic
// depends on ows_pkg, ows_if.sv and the assertion macro header
`include "one_wire_rom_search_unit_defines.svh"

module ows_core (
    input logic            clk,
    input logic            rst_n,
    input logic            space_ok,
    ows_cmd_if.sink        cmd,
    output ows_pkg::push_t push
);
    import ows_pkg::*;

    logic        acc;
    logic        conc;
    logic        ok;
    logic        dir;
    logic [6:0]  pos;
    logic [5:0]  idx;
    logic [2:0]  bidx;
    res_t        r;

    logic [63:0] rom_reg,    rom_next;
    logic [6:0]  ld_reg,     ld_next;
    logic [6:0]  lfd_reg,    lfd_next;
    logic        ldf_reg,    ldf_next;
    logic [6:0]  bpos_reg,   bpos_next;
    logic [6:0]  lzp_reg,    lzp_next;
    logic [7:0]  crc_reg,    crc_next;
    phase_t      phase_reg,  phase_next;
    logic        vmode_reg,  vmode_next;
    logic [63:0] s_rom_reg,  s_rom_next;
    logic [6:0]  s_ld_reg,   s_ld_next;
    logic [6:0]  s_lfd_reg,  s_lfd_next;
    logic        s_ldf_reg,  s_ldf_next;

    function automatic res_t make_res(input action_t a, input logic [7:0] c, input logic d,
                                      input logic f, input logic [63:0] rc,
                                      input logic ldf, input logic last);
        res_t x;
        x.action         = a;
        x.command_byte   = c;
        x.direction      = d;
        x.found          = f;
        x.rom_code       = rc;
        x.is_last_device = ldf;
        x.last_of_run    = last;
        return x;
    endfunction

    assign cmd.ready = space_ok;
    assign acc       = cmd.valid && space_ok;

    always_comb
    begin
        rom_next   = rom_reg;
        ld_next    = ld_reg;
        lfd_next   = lfd_reg;
        ldf_next   = ldf_reg;
        bpos_next  = bpos_reg;
        lzp_next   = lzp_reg;
        crc_next   = crc_reg;
        phase_next = phase_reg;
        vmode_next = vmode_reg;
        s_rom_next = s_rom_reg;
        s_ld_next  = s_ld_reg;
        s_lfd_next = s_lfd_reg;
        s_ldf_next = s_ldf_reg;
        push       = '0;
        conc       = 1'b0;
        ok         = 1'b0;
        dir        = 1'b0;
        pos        = bpos_reg;
        idx        = '0;
        bidx       = '0;
        r          = '0;

        if (acc)
        begin
            case (cmd.op)
                OP_FIRST, OP_NEXT, OP_VERIFY:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        if (cmd.op == OP_FIRST)
                        begin
                            ld_next  = '0;
                            ldf_next = 1'b0;
                            lfd_next = '0;
                        end
                        if (cmd.op == OP_VERIFY)
                        begin
                            s_rom_next = rom_reg;
                            s_ld_next  = ld_reg;
                            s_lfd_next = lfd_reg;
                            s_ldf_next = ldf_reg;
                            vmode_next = 1'b1;
                            ld_next    = ROM_BITS;
                            ldf_next   = 1'b0;
                        end
                        bpos_next = 7'd1;
                        lzp_next  = '0;
                        crc_next  = '0;
                        if (ldf_next)
                            conc = 1'b1;
                        else
                        begin
                            phase_next  = PH_PRESENCE;
                            push.cnt    = 2'd1;
                            push.first  = make_res(ACT_BUS_RESET, 8'h00, 1'b0, 1'b0,
                                                   rom_next, ldf_next, 1'b1);
                        end
                    end
                end
                OP_TARGET:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        rom_next = {56'd0, cmd.family_byte};
                        ld_next  = ROM_BITS;
                        lfd_next = '0;
                        ldf_next = 1'b0;
                    end
                end
                OP_SKIP:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        ld_next = lfd_reg;
                        if (lfd_reg == '0)
                            ldf_next = 1'b1;
                    end
                end
                OP_PRESENCE:
                begin
                    if (phase_reg == PH_PRESENCE)
                    begin
                        if (!cmd.presence)
                        begin
                            ld_next  = '0;
                            ldf_next = 1'b0;
                            lfd_next = '0;
                            conc     = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_BITS;
                            push.cnt   = 2'd1;
                            push.first = make_res(ACT_SEND_CMD, SEARCH_CMD, 1'b0, 1'b0,
                                                  rom_next, ldf_next, 1'b1);
                        end
                    end
                end
                OP_BITS:
                begin
                    if (phase_reg == PH_BITS)
                    begin
                        if (cmd.id_bit && cmd.comp_bit)
                            conc = 1'b1;
                        else
                        begin
                            idx = pos[5:0] - 6'd1;
                            if (cmd.id_bit != cmd.comp_bit)
                                dir = cmd.id_bit;
                            else
                            begin
                                if (pos < ld_reg)
                                    dir = rom_reg[idx];
                                else
                                    dir = (pos == ld_reg);
                                if (!dir)
                                begin
                                    lzp_next = pos;
                                    if (pos < FAMILY_LIMIT)
                                        lfd_next = pos;
                                end
                            end
                            rom_next[idx] = dir;
                            // a full byte has been shifted in
                            if (pos[2:0] == 3'd0)
                            begin
                                bidx     = pos[5:3] - 3'd1;
                                crc_next = crc_byte(crc_reg, rom_next[{bidx, 3'b000} +: 8]);
                            end
                            bpos_next  = pos + 7'd1;
                            push.cnt   = 2'd1;
                            push.first = make_res(ACT_WRITE_DIR, 8'h00, dir, 1'b0, rom_next,
                                                  ldf_next, !(bpos_next >= END_POSITION));
                            if (bpos_next >= END_POSITION)
                                conc = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // end of search: crc and family checks, verify restore
        if (conc)
        begin
            ok = (bpos_next == END_POSITION) && (crc_next == 8'd0);
            if (ok)
            begin
                ld_next = lzp_next;
                if (lzp_next == '0)
                    ldf_next = 1'b1;
                if (lfd_next == lzp_next)
                    lfd_next = '0;
            end
            if (!ok || rom_next[7:0] == 8'd0)
            begin
                ld_next  = '0;
                ldf_next = 1'b0;
                lfd_next = '0;
                ok       = 1'b0;
            end
            if (vmode_next)
            begin
                ok         = ok && (rom_next == s_rom_next);
                rom_next   = s_rom_next;
                ld_next    = s_ld_next;
                lfd_next   = s_lfd_next;
                ldf_next   = s_ldf_next;
                vmode_next = 1'b0;
            end
            phase_next = PH_IDLE;
            r = make_res(ACT_FINISH, 8'h00, 1'b0, ok, rom_next, ldf_next, 1'b1);
            if (push.cnt == 2'd0)
                push.first = r;
            else
                push.second = r;
            push.cnt = push.cnt + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg   <= '0;
            ld_reg    <= '0;
            lfd_reg   <= '0;
            ldf_reg   <= 1'b0;
            bpos_reg  <= 7'd1;
            lzp_reg   <= '0;
            crc_reg   <= '0;
            phase_reg <= PH_IDLE;
            vmode_reg <= 1'b0;
            s_rom_reg <= '0;
            s_ld_reg  <= '0;
            s_lfd_reg <= '0;
            s_ldf_reg <= 1'b0;
        end
        else
        begin
            rom_reg   <= rom_next;
            ld_reg    <= ld_next;
            lfd_reg   <= lfd_next;
            ldf_reg   <= ldf_next;
            bpos_reg  <= bpos_next;
            lzp_reg   <= lzp_next;
            crc_reg   <= crc_next;
            phase_reg <= phase_next;
            vmode_reg <= vmode_next;
            s_rom_reg <= s_rom_next;
            s_ld_reg  <= s_ld_next;
            s_lfd_reg <= s_lfd_next;
            s_ldf_reg <= s_ldf_next;
        end
    end

    // verify always leaves through the end-of-search path
    `OWS_ASSERT_NOW(a_verify_busy, vmode_reg, phase_reg != PH_IDLE, "verify mode while idle")
    // commands during a search produce nothing
    `OWS_ASSERT_NOW(a_busy_cmd_silent,
        acc && phase_reg != PH_IDLE && cmd.op <= OP_SKIP, push.cnt == 2'd0,
        "command accepted during search produced a result")
    // the 64th bit pair always ends the search
    `OWS_ASSERT_NEXT(a_last_bit_ends,
        acc && cmd.op == OP_BITS && phase_reg == PH_BITS && bpos_reg == ROM_BITS,
        phase_reg == PH_IDLE, "search still running after bit 64")

endmodule

/* hw/rtl/ows_res_queue.sv */
// result queue, takes up to two results per cycle and hands out one
// depends on ows_pkg, ows_if.sv and the assertion macro header
`include "one_wire_rom_search_unit_defines.svh"

module ows_res_queue #(
    parameter int DEPTH = 4
) (
    input logic           clk,
    input logic           rst_n,
    input ows_pkg::push_t push,
    output logic          space_ok,
    ows_res_if.source     res
);
    import ows_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_t          mem [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] wr_plus;
    logic          pop;
    res_t          head;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign wr_plus  = ptr_inc(wr_reg);
    assign pop      = res.valid && res.ready;
    assign space_ok = count_reg <= CW'(DEPTH - 2);

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg + CW'(push.cnt) - CW'(pop);
        if (push.cnt == 2'd1)
            wr_next = wr_plus;
        else if (push.cnt == 2'd2)
            wr_next = ptr_inc(wr_plus);
        if (pop)
            rd_next = ptr_inc(rd_reg);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_reg] <= push.first;
        if (push.cnt == 2'd2)
            mem[wr_plus] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    assign head               = mem[rd_reg];
    assign res.valid          = count_reg != '0;
    assign res.action         = head.action;
    assign res.command_byte   = head.command_byte;
    assign res.direction      = head.direction;
    assign res.found          = head.found;
    assign res.rom_code       = head.rom_code;
    assign res.is_last_device = head.is_last_device;
    assign res.last_of_run    = head.last_of_run;

    `OWS_ASSERT_NOW(a_no_overflow, push.cnt != 2'd0,
        (CW + 1)'(count_reg) + (CW + 1)'(push.cnt) <= (CW + 1)'(DEPTH),
        "result queue overflow")
    `OWS_ASSERT_NOW(a_pair_order, push.cnt == 2'd2,
        push.first.action == ACT_WRITE_DIR && !push.first.last_of_run &&
        push.second.action == ACT_FINISH && push.second.last_of_run,
        "two results in one cycle out of order")
    `OWS_ASSERT_NEXT(a_push_shows, count_reg == '0 && push.cnt != 2'd0, res.valid,
        "pushed result not presented")

endmodule

/* hw/rtl/one_wire_rom_search_unit.sv */
// one-wire search rom engine: results of a request are registered in the result queue before they are presented
// throughput one request per cycle while ready is high; a 64th bit pair other than 11 gives two results
// the result queue (QUEUE_DEPTH entries) takes results while the sink stalls
// ready drops when fewer than two queue entries are free
// asynchronous active-low reset: search state cleared, bit position 1, queue empty
// depends on ows_pkg, ows_if.sv, ows_core and ows_res_queue
module one_wire_rom_search_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input logic       clk,
    input logic       rst_n,
    ows_cmd_if.sink   cmd,
    ows_res_if.source res
);
    import ows_pkg::*;

    // results of the accepted request, zero to two per cycle
    push_t push;
    // queue can absorb a worst-case request
    logic  space_ok;

    // search state and per-request decision logic
    ows_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .space_ok (space_ok),
        .cmd      (cmd),
        .push     (push)
    );

    // output buffer that decouples the result sink from the request side
    ows_res_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .res      (res)
    );

endmodule
